@@ rtl/assert_macros.svh @@
// Assertion macros used by the deadband controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/pwdb_pkg.sv @@
// Package with types, constants and helpers for the deadband block.
package pwdb_pkg;
  localparam int WidthBits   = 16;
  localparam int MaxCal      = 512;
  localparam int CalLimit    = 500;
  localparam int AddrBits    = $clog2(MaxCal);
  localparam int IdxBits     = AddrBits + 1;
  localparam int CntBits     = 9;
  localparam int SumBits     = 25;
  localparam int SqBits      = 2 * WidthBits + AddrBits;
  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] CFG_CAL_COUNT = 1'b0;
  localparam logic [CfgIdxBits-1:0] CFG_PRESET    = 1'b1;

  typedef struct packed {
    logic [WidthBits-1:0] width;
    logic                 mode;
  } in_word_t;

  typedef struct packed {
    logic [WidthBits-1:0] held_width;
    logic [WidthBits-1:0] offset_now;
    logic                 deadband_active;
    logic                 calibration_done;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic filter;      // apply the deadband filter to the latched word
    logic cal_append;  // store held value, bump index and sum
    logic cal_clear;   // drop a partial run
    logic mean_start;  // start sum / N
    logic sq_start;    // latch the mean, clear the square accumulator and read entry 0
    logic sq_step;     // accumulate one entry
    logic q_start;     // start square sum / N
    logic root_start;  // start offset search
    logic finish;      // load offset, enable deadband, clear run
  } dp_cmd_t;

  typedef struct packed {
    logic cal_valid;   // count register is usable
    logic run_full;    // index reached the count after append
    logic div_busy;
    logic sq_last;     // last entry being accumulated
    logic root_busy;
  } dp_stat_t;
endpackage

@@ rtl/pulse_width_deadband_calibrated_unit.sv @@
// Top level of the calibrated pulse-width deadband filter.
// Usage: each input word carries a measured pulse width and a mode bit (0 normal,
// 1 calibration). Every accepted word yields exactly one result word with the
// held width, the offset in use, the deadband enable and a calibration-done flag.
// Both channels use valid/ready; a word moves when valid and ready are high.
// A normal word's result goes from S_FILT to the output register; a calibration
// word that does not end a run also passes S_CAL. The word ending a run walks the
// calibration store: one divider pass for the mean, one store sweep of N entries,
// a second divider pass for q, then a binary search of up to 16 probes, each a
// square and then a compare.
// The block handles one word at a time.
// The result sits in the output register while out_ready is low, and no new
// input word is taken until it is delivered.
// Reset (synchronous, rst_n low) clears the held width, offset, deadband enable
// and calibration progress and sets the sample count to 500. The store needs
// no clearing: only entries written in the current run are read.
// The configuration port writes the count (index 0, drops a partial run) or a
// preset offset (index 1, enables the deadband); write it only while idle.
module pulse_width_deadband_calibrated_unit
  import pwdb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_data,
  input  logic                   cfg_we,
  input  logic [CfgIdxBits-1:0]  cfg_index,
  input  logic [CfgDataBits-1:0] cfg_data
);
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_word_t dp_result;
  logic      in_load;
  logic      done_flag;

  pwdb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_ready  (in_ready),
    .in_load   (in_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .done_flag (done_flag),
    .cmd       (cmd),
    .stat      (stat)
  );

  pwdb_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_load  (in_load),
    .in_word  (in_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .result   (dp_result)
  );

  // The done flag comes from the controller; the rest from datapath registers.
  always_comb begin
    out_data                  = dp_result;
    out_data.calibration_done = done_flag;
  end
endmodule

@@ rtl/pwdb_ram.sv @@
// Generic single-port RAM with registered read.
module pwdb_ram #(
  parameter int Width = 16,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ rtl/pwdb_div.sv @@
// Restoring divider, one quotient bit per cycle.
module pwdb_div
  import pwdb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SqBits-1:0] dividend,
  input  logic [CntBits-1:0] divisor,
  output logic              busy,
  output logic [SqBits-1:0] quotient
);
  localparam int StepBits = $clog2(SqBits + 1);

  logic [SqBits-1:0]   quo_r, quo_nxt;
  logic [CntBits:0]    rem_r, rem_nxt;
  logic [StepBits-1:0] cnt_r, cnt_nxt;
  logic [CntBits:0]    trial;

  assign trial = {rem_r[CntBits-1:0], quo_r[SqBits-1]};

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = StepBits'(SqBits);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        quo_nxt = {quo_r[SqBits-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[SqBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign busy     = cnt_r != '0;
  assign quotient = quo_r;
endmodule

@@ rtl/pwdb_datapath.sv @@
// Datapath: filter, calibration store, accumulators, divider and offset search.
module pwdb_datapath
  import pwdb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_load,
  input  in_word_t               in_word,
  input  logic                   cfg_we,
  input  logic [CfgIdxBits-1:0]  cfg_idx,
  input  logic [CfgDataBits-1:0] cfg_data,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  output out_word_t              result
);
  localparam int RootSteps = WidthBits;
  localparam int RsBits    = $clog2(RootSteps + 1);

  logic [WidthBits-1:0] held_r, held_nxt, off_r, off_nxt, w_r;
  logic                 db_r, db_nxt;
  logic [CntBits-1:0]   count_r;
  logic [IdxBits-1:0]   idx_r, idx_nxt;
  logic [SumBits-1:0]   sum_r, sum_nxt;
  logic [SqBits-1:0]    sq_r;
  logic [WidthBits-1:0] mean_r;
  logic [AddrBits-1:0]  rd_ptr_r, ram_addr;
  logic [IdxBits-1:0]   rd_cnt_r;
  logic                 acc_en_r;
  logic [WidthBits-1:0] ram_q, diff;
  logic [2*WidthBits-1:0] diff_sq_r;
  logic                 sq_pend_r;
  logic [WidthBits:0]   upper;
  logic [WidthBits-1:0] lower;
  logic                 div_start, div_busy;
  logic [SqBits-1:0]    div_dividend, div_q;
  logic [WidthBits-1:0] lo_r, hi_r, mid;
  logic [RsBits-1:0]    rs_r;
  logic [WidthBits+5:0] a_val;
  logic [2*WidthBits+11:0] a_sq_r, rhs_r;
  logic                 cmp_pend_r;
  logic [WidthBits:0]   span;

  // Deadband filter.
  assign upper = {1'b0, held_r} + {1'b0, off_r};
  assign lower = (held_r > off_r) ? held_r - off_r : '0;

  always_comb begin
    held_nxt = held_r;
    off_nxt  = off_r;
    db_nxt   = db_r;
    idx_nxt  = idx_r;
    sum_nxt  = sum_r;
    if (cmd.filter) begin
      if (!db_r || ({1'b0, w_r} > upper) || (w_r < lower)) begin
        held_nxt = w_r;
      end
    end
    if (cmd.cal_append) begin
      idx_nxt = idx_r + 1'b1;
      sum_nxt = sum_r + SumBits'(held_r);
    end
    if (cmd.cal_clear || cmd.finish) begin
      idx_nxt = '0;
      sum_nxt = '0;
    end
    if (cmd.finish) begin
      off_nxt = lo_r;
      db_nxt  = 1'b1;
    end
    if (cfg_we && cfg_idx == CFG_CAL_COUNT) begin
      idx_nxt = '0;
      sum_nxt = '0;
    end else if (cfg_we && cfg_idx == CFG_PRESET) begin
      off_nxt = cfg_data[WidthBits-1:0];
      db_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      off_r   <= '0;
      db_r    <= 1'b0;
      idx_r   <= '0;
      sum_r   <= '0;
      count_r <= CntBits'(CalLimit);
    end else begin
      held_r <= held_nxt;
      off_r  <= off_nxt;
      db_r   <= db_nxt;
      idx_r  <= idx_nxt;
      sum_r  <= sum_nxt;
      if (cfg_we && cfg_idx == CFG_CAL_COUNT) begin
        count_r <= cfg_data[CntBits-1:0];
      end
    end
    if (in_load) begin
      w_r <= in_word.width;
    end
  end

  // Calibration store: written on append, swept during the square sum.
  assign ram_addr = cmd.cal_append ? idx_r[AddrBits-1:0] : rd_ptr_r;

  pwdb_ram #(.Width(WidthBits), .Depth(MaxCal)) u_store (
    .clk   (clk),
    .we    (cmd.cal_append),
    .addr  (ram_addr),
    .wdata (held_r),
    .rdata (ram_q)
  );

  assign diff = (ram_q >= mean_r) ? ram_q - mean_r : mean_r - ram_q;

  // Sweep: address counter, registered store read, then a registered square, then accumulate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r  <= 1'b0;
      sq_pend_r <= 1'b0;
      rd_ptr_r  <= '0;
      rd_cnt_r  <= '0;
    end else begin
      acc_en_r  <= cmd.sq_step;
      sq_pend_r <= acc_en_r;
      if (cmd.sq_start) begin
        rd_ptr_r <= '0;
        rd_cnt_r <= '0;
      end else if (cmd.sq_step) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
    end
    diff_sq_r <= diff * diff;
    if (cmd.sq_start) begin
      sq_r <= '0;
    end else if (sq_pend_r) begin
      sq_r <= sq_r + SqBits'(diff_sq_r);
    end
  end

  // Shared divider: first for the mean, then for q.
  assign div_start    = cmd.mean_start || cmd.q_start;
  assign div_dividend = cmd.mean_start ? SqBits'(sum_r) : sq_r;

  pwdb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.sq_start) begin
      mean_r <= div_q[WidthBits-1:0];
    end
  end

  // Binary search for the largest r with (20r-10)^2 <= 169q.
  // Each probe has two steps: square, then compare.
  assign span  = {1'b0, hi_r} - {1'b0, lo_r} + 1'b1;
  assign mid   = lo_r + span[WidthBits:1];
  assign a_val = (WidthBits+6)'(mid) * 6'd20 - 6'd10;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r       <= '0;
      cmp_pend_r <= 1'b0;
    end else if (cmd.root_start) begin
      rs_r       <= RsBits'(RootSteps + 1);
      cmp_pend_r <= 1'b0;
    end else if (rs_r != '0) begin
      if (!cmp_pend_r) begin
        if (lo_r >= hi_r) begin
          rs_r <= '0;
        end else begin
          cmp_pend_r <= 1'b1;
        end
      end else begin
        cmp_pend_r <= 1'b0;
        rs_r       <= rs_r - 1'b1;
      end
    end
    if (cmd.root_start) begin
      lo_r  <= '0;
      hi_r  <= '1;
      rhs_r <= (2*WidthBits+12)'(div_q) * 8'd169;
    end else if (rs_r != '0) begin
      if (!cmp_pend_r) begin
        a_sq_r <= (2*WidthBits+12)'(a_val) * (2*WidthBits+12)'(a_val);
      end else if (a_sq_r <= rhs_r) begin
        lo_r <= mid;
      end else begin
        hi_r <= mid - 1'b1;
      end
    end
  end

  assign stat.cal_valid = (count_r != '0) && (count_r <= CntBits'(CalLimit))
                          && ({1'b0, count_r} <= IdxBits'(MaxCal));
  assign stat.run_full  = (idx_r + 1'b1) >= IdxBits'(count_r);
  assign stat.div_busy  = div_busy;
  assign stat.sq_last   = (rd_cnt_r + 1'b1) >= IdxBits'(count_r);
  assign stat.root_busy = rs_r != '0;

  assign result.held_width       = held_r;
  assign result.offset_now       = off_r;
  assign result.deadband_active  = db_r;
  assign result.calibration_done = 1'b0;
endmodule

@@ rtl/pwdb_ctrl.sv @@
// Controller state machine sequencing filter, calibration and handshakes.
module pwdb_ctrl
  import pwdb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_mode,
  output logic     in_ready,
  output logic     in_load,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     done_flag,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);
  `include "assert_macros.svh"

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_FILT   = 10'b00_0000_0010,
    S_CAL    = 10'b00_0000_0100,
    S_MEAN   = 10'b00_0000_1000,
    S_SQINIT = 10'b00_0001_0000,
    S_SQ     = 10'b00_0010_0000,
    S_SQWAIT = 10'b00_0100_0000,
    S_QDIV   = 10'b00_1000_0000,
    S_ROOT   = 10'b01_0000_0000,
    S_OUT    = 10'b10_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic       mode_r;
  logic       done_r, done_nxt;
  logic [1:0] drain_r, drain_nxt;
  logic       wait_r, wait_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign in_load   = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign done_flag = done_r;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    drain_nxt = drain_r;
    wait_nxt  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_load) begin
          state_nxt = S_FILT;
        end
      end
      S_FILT: begin
        cmd.filter = 1'b1;
        done_nxt   = 1'b0;
        if (mode_r && stat.cal_valid) begin
          state_nxt = S_CAL;
        end else begin
          cmd.cal_clear = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_CAL: begin
        cmd.cal_append = 1'b1;
        if (stat.run_full) begin
          state_nxt = S_MEAN;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_MEAN: begin
        cmd.mean_start = 1'b1;
        wait_nxt       = 1'b1;
        state_nxt      = S_SQINIT;
      end
      S_SQINIT: begin
        if (!wait_r && !stat.div_busy) begin
          cmd.sq_start = 1'b1;
          state_nxt    = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        if (stat.sq_last) begin
          drain_nxt = 2'd3;
          state_nxt = S_SQWAIT;
        end
      end
      S_SQWAIT: begin
        if (drain_r == 2'd0) begin
          cmd.q_start = 1'b1;
          wait_nxt    = 1'b1;
          state_nxt   = S_QDIV;
        end else begin
          drain_nxt = drain_r - 1'b1;
        end
      end
      S_QDIV: begin
        if (!wait_r && !stat.div_busy) begin
          cmd.root_start = 1'b1;
          wait_nxt       = 1'b1;
          state_nxt      = S_ROOT;
        end
      end
      S_ROOT: begin
        if (!wait_r && !stat.root_busy) begin
          cmd.finish = 1'b1;
          done_nxt   = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      drain_r <= '0;
      wait_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      drain_r <= drain_nxt;
      wait_r  <= wait_nxt;
    end
    if (in_load) begin
      mode_r <= in_mode;
    end
  end

  `ASSERT_IMPL(a_onehot, clk, rst_n, 1'b1, $onehot(state_r), "state not one-hot")
  `ASSERT_NEXT(a_load_filt, clk, rst_n, in_load, state_r == S_FILT,
               "accepted word not filtered next")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid,
               "result dropped while stalled")
  `ASSERT_IMPL(a_done_out, clk, rst_n, state_r == S_IDLE && in_valid, !out_valid,
               "input taken while result pending")
endmodule
